// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands for the furnace door motion controller.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fdmc_pkg.sv
// ----------------------------------------------------------------------------
// fdmc_pkg
// Types, codes and reset values shared by the door motion controller.
// ----------------------------------------------------------------------------
package fdmc_pkg;

	localparam int TICKS_PER_SECOND_DEF = 10;
	localparam int CNT_W = 12;
	localparam logic [CNT_W-1:0] COUNT_MAX = 12'd4095;

	localparam logic [7:0]  TIMEOUT_RST = 8'd120;
	localparam logic [7:0]  RUN_RST     = 8'd100;
	localparam logic [11:0] TEMP_RST    = 12'd1200;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RUN     = 2'd1;
	localparam logic [1:0] REG_TEMP    = 2'd2;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_RAISE = 2'd1;
	localparam logic [1:0] MODE_LOWER = 2'd2;
	localparam logic [1:0] MODE_STOP  = 2'd3;

	localparam logic [1:0] DRIVE_OFF   = 2'd0;
	localparam logic [1:0] DRIVE_RAISE = 2'd1;
	localparam logic [1:0] DRIVE_LOWER = 2'd2;

	localparam logic [2:0] STAT_IDLE     = 3'd0;
	localparam logic [2:0] STAT_MOVING   = 3'd1;
	localparam logic [2:0] STAT_LIMIT    = 3'd2;
	localparam logic [2:0] STAT_STOPPED  = 3'd3;
	localparam logic [2:0] STAT_RUN_DONE = 3'd4;
	localparam logic [2:0] STAT_TOO_HOT  = 3'd5;
	localparam logic [2:0] STAT_AT_LIMIT = 3'd6;
	localparam logic [2:0] STAT_FAULT    = 3'd7;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RAISE = 2'd1;
	localparam logic [1:0] ST_LOWER = 2'd2;
	localparam logic [1:0] ST_FAULT = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic        up_limit_hit;
		logic        down_limit_hit;
		logic [11:0] temperature;
	} in_item_t;

	typedef struct packed {
		logic [1:0] drive;
		logic [2:0] status;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  timeout_seconds;
		logic [7:0]  run_seconds;
		logic [11:0] temp_limit;
	} cfg_t;

endpackage

// File: design/fdmc_ctrl.sv
// ----------------------------------------------------------------------------
// fdmc_ctrl
// Motion state and tick counters; computes one result for each stepped beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdmc_ctrl #(
	parameter int TICKS_PER_SECOND = fdmc_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  fdmc_pkg::in_item_t  item,
	input  fdmc_pkg::cfg_t      cfg,
	output fdmc_pkg::out_item_t res
);

	localparam int TW = $clog2(TICKS_PER_SECOND + 1);
	localparam int PW = (8 + TW > 13) ? 8 + TW : 13;
	localparam int CW = fdmc_pkg::CNT_W;

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] timeout_q, timeout_d;
	logic [CW-1:0] run_q, run_d;

	logic [PW-1:0] tmo_prod, run_prod;
	logic [CW-1:0] tmo_load, run_sat, run_load;
	logic [CW-1:0] tmo_dec, run_dec;
	logic          run_done;

	assign tmo_prod = PW'(cfg.timeout_seconds) * PW'(TICKS_PER_SECOND);
	assign run_prod = PW'(cfg.run_seconds) * PW'(TICKS_PER_SECOND);
	assign tmo_load = (tmo_prod > PW'(fdmc_pkg::COUNT_MAX)) ? fdmc_pkg::COUNT_MAX
		: tmo_prod[CW-1:0];
	assign run_sat  = (run_prod > PW'(fdmc_pkg::COUNT_MAX)) ? fdmc_pkg::COUNT_MAX
		: run_prod[CW-1:0];
	assign run_load = (cfg.run_seconds != 8'd0) ? run_sat : tmo_load;

	assign tmo_dec  = (timeout_q != '0) ? timeout_q - CW'(1) : '0;
	assign run_dec  = (run_q != '0) ? run_q - CW'(1) : '0;
	assign run_done = (run_dec == '0);

	always_comb begin
		state_d   = state_q;
		timeout_d = timeout_q;
		run_d     = run_q;
		res.drive  = fdmc_pkg::DRIVE_OFF;
		res.status = fdmc_pkg::STAT_IDLE;
		case (state_q)
			fdmc_pkg::ST_FAULT: begin
				res.status = fdmc_pkg::STAT_FAULT;
			end
			fdmc_pkg::ST_IDLE: begin
				if ((item.mode == fdmc_pkg::MODE_RAISE && item.up_limit_hit) ||
				    (item.mode == fdmc_pkg::MODE_LOWER &&
				     item.temperature <= cfg.temp_limit && item.down_limit_hit)) begin
					res.status = fdmc_pkg::STAT_AT_LIMIT;
				end else if (item.mode == fdmc_pkg::MODE_LOWER &&
				             item.temperature > cfg.temp_limit) begin
					res.status = fdmc_pkg::STAT_TOO_HOT;
				end else if (item.mode == fdmc_pkg::MODE_RAISE ||
				             item.mode == fdmc_pkg::MODE_LOWER) begin
					timeout_d = tmo_load;
					run_d     = run_load;
					if (tmo_load == '0) begin
						state_d    = fdmc_pkg::ST_FAULT;
						res.status = fdmc_pkg::STAT_FAULT;
					end else begin
						state_d    = (item.mode == fdmc_pkg::MODE_RAISE) ?
							fdmc_pkg::ST_RAISE : fdmc_pkg::ST_LOWER;
						res.drive  = (item.mode == fdmc_pkg::MODE_RAISE) ?
							fdmc_pkg::DRIVE_RAISE : fdmc_pkg::DRIVE_LOWER;
						res.status = fdmc_pkg::STAT_MOVING;
					end
				end
			end
			default: begin
				timeout_d = tmo_dec;
				run_d     = run_dec;
				state_d   = fdmc_pkg::ST_IDLE;
				if (tmo_dec == '0) begin
					state_d    = fdmc_pkg::ST_FAULT;
					res.status = fdmc_pkg::STAT_FAULT;
				end else if (state_q == fdmc_pkg::ST_RAISE) begin
					if (item.up_limit_hit) begin
						res.status = fdmc_pkg::STAT_LIMIT;
					end else if (item.mode == fdmc_pkg::MODE_STOP) begin
						res.status = fdmc_pkg::STAT_STOPPED;
					end else if (run_done) begin
						res.status = fdmc_pkg::STAT_RUN_DONE;
					end else begin
						state_d    = state_q;
						res.drive  = fdmc_pkg::DRIVE_RAISE;
						res.status = fdmc_pkg::STAT_MOVING;
					end
				end else begin
					if (run_done) begin
						res.status = fdmc_pkg::STAT_RUN_DONE;
					end else if (item.down_limit_hit) begin
						res.status = fdmc_pkg::STAT_LIMIT;
					end else if (item.mode == fdmc_pkg::MODE_STOP) begin
						res.status = fdmc_pkg::STAT_STOPPED;
					end else begin
						state_d    = state_q;
						res.drive  = fdmc_pkg::DRIVE_LOWER;
						res.status = fdmc_pkg::STAT_MOVING;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fdmc_pkg::ST_IDLE;
			timeout_q <= '0;
			run_q     <= '0;
		end else if (step) begin
			state_q   <= state_d;
			timeout_q <= timeout_d;
			run_q     <= run_d;
		end
	end

	`ASSERT_NEXT(a_fault_sticky, state_q == fdmc_pkg::ST_FAULT,
		state_q == fdmc_pkg::ST_FAULT, "fault state left before reset")
	`ASSERT_IMPL(a_moving_has_time,
		state_q == fdmc_pkg::ST_RAISE || state_q == fdmc_pkg::ST_LOWER,
		timeout_q != '0, "moving with an exhausted timeout")
	`ASSERT_NEXT(a_state_only_on_step, !step, $stable(state_q),
		"motion state changed without a beat")

endmodule

// File: design/furnace_door_motion_controller.sv
// ----------------------------------------------------------------------------
// furnace_door_motion_controller
// Door motor control per 100 ms tick beat, with an APB register port.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall  | in_item  (mode, limits, temperature)
// out      | output    | out_valid/out_stall| out_item (drive, status)
// apb      | input     | psel/penable       | timeout, run time, temp limit
//
// One beat per cycle while the result is not stalled; a taken beat is held in the
// input stage register, then written to the result register when it advances.
// Reset clears control, counters, motion state and registers to defaults.
// A stalled result holds; the input stage fills behind it, then in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module furnace_door_motion_controller #(
	parameter int TICKS_PER_SECOND = fdmc_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  fdmc_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output fdmc_pkg::out_item_t         out_item,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fdmc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	fdmc_pkg::cfg_t      cfg_q;
	fdmc_pkg::in_item_t  item_s1;
	fdmc_pkg::out_item_t res;
	fdmc_pkg::out_item_t out_q;
	logic                valid_s1;
	logic                out_valid_q;
	logic                advance;
	logic                in_take;
	logic                wr_en;
	logic [1:0]          reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_seconds <= fdmc_pkg::TIMEOUT_RST;
			cfg_q.run_seconds     <= fdmc_pkg::RUN_RST;
			cfg_q.temp_limit      <= fdmc_pkg::TEMP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				fdmc_pkg::REG_TIMEOUT: cfg_q.timeout_seconds <= pwdata[7:0];
				fdmc_pkg::REG_RUN:     cfg_q.run_seconds     <= pwdata[7:0];
				fdmc_pkg::REG_TEMP:    cfg_q.temp_limit      <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fdmc_pkg::REG_TIMEOUT: prdata = {24'd0, cfg_q.timeout_seconds};
			fdmc_pkg::REG_RUN:     prdata = {24'd0, cfg_q.run_seconds};
			fdmc_pkg::REG_TEMP:    prdata = {20'd0, cfg_q.temp_limit};
			default:               prdata = 32'd0;
		endcase
	end

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_item;
		end
	end

	fdmc_ctrl #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`ASSERT_IMPL(a_stall_needs_beat, in_stall, valid_s1 && out_valid_q && out_stall,
		"input stalled without a blocked beat")
	`ASSERT_NEXT(a_free_stage_moves, valid_s1 && !out_valid_q, out_valid_q,
		"held beat did not reach the result register")
	`ASSERT_IMPL(a_drive_means_moving,
		out_valid_q && out_q.drive != fdmc_pkg::DRIVE_OFF,
		out_q.status == fdmc_pkg::STAT_MOVING, "motor driven without moving status")

endmodule

// File: test/furnace_door_motion_controller_tb.sv
// ----------------------------------------------------------------------------
// furnace_door_motion_controller_tb
// Drives tick beats into the door motion controller and checks each result
// beat against a cycle-free model of the door state, its countdown counters
// and the register settings. A directed run of commands and switch cases
// comes first. Random ticks then run under several register settings, with
// sender gaps and receiver stalls. The run ends on a timeout fault.
// ----------------------------------------------------------------------------
module furnace_door_motion_controller_tb;
	import fdmc_pkg::*;

	class door_motion_checker;
		logic [7:0]  timeout_s = TIMEOUT_RST;
		logic [7:0]  run_s = RUN_RST;
		logic [11:0] temp_lim = TEMP_RST;
		logic [1:0]  motion = ST_IDLE;
		logic [11:0] timeout_left = '0;
		logic [11:0] run_left = '0;
		out_item_t   expected_q[$];
		int          errors = 0;
		int          ticks = 0;
		int          results = 0;
		bit          status_seen[8];

		function logic [11:0] load_ticks(logic [7:0] secs);
			int t;
			t = int'(secs) * TICKS_PER_SECOND_DEF;
			return (t > int'(COUNT_MAX)) ? COUNT_MAX : t[11:0];
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
			REG_TIMEOUT: timeout_s = val[7:0];
			REG_RUN: run_s = val[7:0];
			REG_TEMP: temp_lim = val[11:0];
			default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
			REG_TIMEOUT: return {24'd0, timeout_s};
			REG_RUN: return {24'd0, run_s};
			REG_TEMP: return {20'd0, temp_lim};
			default: return '0;
			endcase
		endfunction

		function out_item_t start_motion(logic [1:0] dir);
			out_item_t r;
			timeout_left = load_ticks(timeout_s);
			run_left = (run_s != 0) ? load_ticks(run_s) : timeout_left;
			if (timeout_left == 0) begin
				motion = ST_FAULT;
				r.drive = DRIVE_OFF;
				r.status = STAT_FAULT;
				return r;
			end
			motion = dir;
			r.drive = (dir == ST_RAISE) ? DRIVE_RAISE : DRIVE_LOWER;
			r.status = STAT_MOVING;
			return r;
		endfunction

		function out_item_t end_motion(logic [2:0] why);
			out_item_t r;
			motion = ST_IDLE;
			r.drive = DRIVE_OFF;
			r.status = why;
			return r;
		endfunction

		function bit moving();
			return motion == ST_RAISE || motion == ST_LOWER;
		endfunction

		function void note_tick(in_item_t t);
			out_item_t r;
			logic      run_done;
			ticks++;
			r.drive = DRIVE_OFF;
			r.status = STAT_IDLE;
			case (motion)
			ST_FAULT: r.status = STAT_FAULT;
			ST_IDLE: begin
				if (t.mode == MODE_RAISE) begin
					if (t.up_limit_hit)
						r.status = STAT_AT_LIMIT;
					else
						r = start_motion(ST_RAISE);
				end else if (t.mode == MODE_LOWER) begin
					if (t.temperature > temp_lim)
						r.status = STAT_TOO_HOT;
					else if (t.down_limit_hit)
						r.status = STAT_AT_LIMIT;
					else
						r = start_motion(ST_LOWER);
				end
			end
			default: begin
				if (timeout_left != 0)
					timeout_left = timeout_left - 1'b1;
				if (run_left != 0)
					run_left = run_left - 1'b1;
				run_done = (run_left == 0);
				if (timeout_left == 0) begin
					motion = ST_FAULT;
					r.status = STAT_FAULT;
				end else if (motion == ST_RAISE) begin
					if (t.up_limit_hit)
						r = end_motion(STAT_LIMIT);
					else if (t.mode == MODE_STOP)
						r = end_motion(STAT_STOPPED);
					else if (run_done)
						r = end_motion(STAT_RUN_DONE);
					else begin
						r.drive = DRIVE_RAISE;
						r.status = STAT_MOVING;
					end
				end else begin
					if (run_done)
						r = end_motion(STAT_RUN_DONE);
					else if (t.down_limit_hit)
						r = end_motion(STAT_LIMIT);
					else if (t.mode == MODE_STOP)
						r = end_motion(STAT_STOPPED);
					else begin
						r.drive = DRIVE_LOWER;
						r.status = STAT_MOVING;
					end
				end
			end
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			results++;
			if (!$isunknown(got.status))
				status_seen[got.status] = 1'b1;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: drive %0d status %0d", got.drive, got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.drive !== want.drive) begin
				$error("drive: expected %0d, got %0d", want.drive, got.drive);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_item;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	door_motion_checker  sb;
	int                  src_idle_pct;
	int                  stall_pct;

	furnace_door_motion_controller u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(out_item);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic in_item_t tick_of(logic [1:0] mode, logic up, logic dn, logic [11:0] temp);
		in_item_t t;
		t.mode = mode;
		t.up_limit_hit = up;
		t.down_limit_hit = dn;
		t.temperature = temp;
		return t;
	endfunction

	function automatic in_item_t random_tick();
		in_item_t t;
		int       r;
		int       temp;
		r = $urandom_range(99);
		t.mode = (r < 60) ? MODE_NONE : (r < 78) ? MODE_RAISE : (r < 95) ? MODE_LOWER : MODE_STOP;
		t.up_limit_hit = ($urandom_range(15) == 0);
		t.down_limit_hit = ($urandom_range(15) == 0);
		if ($urandom_range(9) < 4) begin
			temp = int'(sb.temp_lim) + int'($urandom_range(8)) - 4;
			if (temp < 0)
				temp = 0;
			if (temp > 4095)
				temp = 4095;
		end else
			temp = $urandom_range(4095);
		t.temperature = temp[11:0];
		// stop before the timeout can expire; the fault is kept for the end
		if (sb.moving() && sb.timeout_left <= 2)
			t.mode = MODE_STOP;
		return t;
	endfunction

	task automatic send_tick(in_item_t t);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= t;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_tick(t);
	endtask

	task automatic run_random(int n);
		repeat (n) send_tick(random_tick());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
	endtask

	task automatic set_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] rd;
		apb_xfer(1'b1, idx, val, rd);
		sb.write_reg(idx, val);
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== sb.reg_value(idx)) begin
			$error("register %0d: expected %0h, got %0h", idx, sb.reg_value(idx), rd);
			sb.errors++;
		end
	endtask

	task automatic configure(logic [7:0] timeout_s, logic [7:0] run_s, logic [11:0] temp_lim);
		drain();
		set_reg(REG_TIMEOUT, {24'd0, timeout_s});
		set_reg(REG_RUN, {24'd0, run_s});
		set_reg(REG_TEMP, {20'd0, temp_lim});
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		#2_000_000;
		$display("furnace_door_motion_controller_tb failed");
		$finish;
	end

	initial begin
		int codes;
		sb = new();
		src_idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(8'd5, 8'd2, 12'd1200);
		send_tick(tick_of(MODE_NONE, 1'b0, 1'b0, 12'd0));
		send_tick(tick_of(MODE_STOP, 1'b1, 1'b1, 12'd4095));
		send_tick(tick_of(MODE_RAISE, 1'b1, 1'b0, 12'd0));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b1, 12'd4095));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b1, 12'd1200));
		send_tick(tick_of(MODE_LOWER, 1'b1, 1'b0, 12'd1200));
		send_tick(tick_of(MODE_RAISE, 1'b1, 1'b0, 12'd0));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b0, 12'd4095));
		send_tick(tick_of(MODE_STOP, 1'b0, 1'b1, 12'd0));
		send_tick(tick_of(MODE_RAISE, 1'b0, 1'b1, 12'd4095));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b0, 12'd0));
		send_tick(tick_of(MODE_STOP, 1'b1, 1'b0, 12'd0));
		send_tick(tick_of(MODE_RAISE, 1'b0, 1'b0, 12'd0));
		send_tick(tick_of(MODE_STOP, 1'b0, 1'b1, 12'd0));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b0, 12'd1201));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b0, 12'd0));
		send_tick(tick_of(MODE_STOP, 1'b0, 1'b0, 12'd0));

		configure(8'd3, 8'd1, 12'd1200);
		src_idle_pct = 25;
		stall_pct = 49;
		run_random(200);

		configure(8'd255, 8'd0, 12'd0);
		src_idle_pct = 49;
		stall_pct = 25;
		run_random(200);

		configure(8'd2, 8'd255, 12'd4095);
		src_idle_pct = 0;
		stall_pct = 0;
		run_random(200);

		configure(8'd1, 8'd1, 12'd2000);
		run_random(200);

		// run time zero follows the timeout, so the countdown ends in a fault
		configure(8'd1, 8'd0, 12'd2000);
		send_tick(tick_of(MODE_RAISE, 1'b0, 1'b0, 12'd100));
		repeat (9) send_tick(tick_of(MODE_NONE, 1'b0, 1'b0, 12'd100));
		send_tick(tick_of(MODE_STOP, 1'b1, 1'b1, 12'd100));
		send_tick(tick_of(MODE_RAISE, 1'b0, 1'b0, 12'd100));
		send_tick(tick_of(MODE_LOWER, 1'b0, 1'b0, 12'd0));

		drain();
		repeat (10) @(posedge clk);
		codes = 0;
		foreach (sb.status_seen[i])
			codes += sb.status_seen[i];
		$display("%0d tick beats and %0d result beats over six register settings,", sb.ticks,
			sb.results);
		$display("%0d of 8 status codes seen, ending in a latched timeout fault", codes);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("furnace_door_motion_controller_tb passed");
		else
			$display("furnace_door_motion_controller_tb failed");
		$finish;
	end
endmodule
